// ===== rtl/bffm_pkg.sv =====
// shared types and constants for the blob flood fill moments block
// controller commands, datapath status, state encoding and neighbor tables
`timescale 1ns / 1ps

package bffm_pkg;

	localparam int CW = 11;
	localparam int DIM_W = 7;
	localparam int COORD_W = 6;
	localparam int VALUE_W = 8;
	localparam int CNT_W = 13;
	localparam int SUM_W = 17;
	localparam int SQ_W = 23;
	localparam int XY_W = 22;

	localparam logic [VALUE_W-1:0] FG_VALUE = 8'd1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_FIND = 1'b1;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic signed [1:0] NB_DY [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
		2'sd0, 2'sd1, 2'sd1, 2'sd1};
	localparam logic signed [1:0] NB_DX [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
		2'sd1, -2'sd1, 2'sd0, 2'sd1};

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SREQ,
		ST_SCHK,
		ST_POP,
		ST_TAKE,
		ST_NREQ,
		ST_NCHK,
		ST_DONE_HIT,
		ST_DONE_MISS
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic pix_wr;
		logic scan_rd;
		logic scan_chk;
		logic pop_rd;
		logic take;
		logic nb_rd;
		logic nb_chk;
		logic load_res;
		logic res_found;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic scan_end;
		logic scan_hit;
		logic stack_empty;
		logic nb_last;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== rtl/bffm_ctrl.sv =====
// sequencer for clearing, pixel writes, raster scan and flood fill
// depends on bffm_pkg for state, command and status types
`timescale 1ns / 1ps

module bffm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 command,
	output logic                 in_ready,
	input  bffm_pkg::dp_status_t status,
	output bffm_pkg::dp_cmd_t    cmd
);
	import bffm_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && command == CMD_FIND) state_d = ST_SREQ;
			end
			ST_SREQ: begin
				state_d = status.scan_end ? ST_DONE_MISS : ST_SCHK;
			end
			ST_SCHK: begin
				state_d = status.scan_hit ? ST_POP : ST_SREQ;
			end
			ST_POP: begin
				state_d = status.stack_empty ? ST_DONE_HIT : ST_TAKE;
			end
			ST_TAKE: begin
				state_d = ST_NREQ;
			end
			ST_NREQ: begin
				state_d = ST_NCHK;
			end
			ST_NCHK: begin
				state_d = status.nb_last ? ST_POP : ST_NREQ;
			end
			ST_DONE_HIT, ST_DONE_MISS: begin
				if (!status.out_busy) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.pix_wr = in_valid && command == CMD_WRITE;
			end
			ST_SREQ: cmd.scan_rd = !status.scan_end;
			ST_SCHK: cmd.scan_chk = 1'b1;
			ST_POP: cmd.pop_rd = !status.stack_empty;
			ST_TAKE: cmd.take = 1'b1;
			ST_NREQ: cmd.nb_rd = 1'b1;
			ST_NCHK: cmd.nb_chk = 1'b1;
			ST_DONE_HIT: begin
				cmd.load_res = !status.out_busy;
				cmd.res_found = 1'b1;
			end
			ST_DONE_MISS: cmd.load_res = !status.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/bffm_datapath.sv =====
// pixel store with visited marks, fill stack, scan position, moment sums
// and result register; depends on bffm_pkg
`timescale 1ns / 1ps

module bffm_datapath #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bffm_pkg::dp_cmd_t             cmd,
	output bffm_pkg::dp_status_t          status,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic [bffm_pkg::DIM_W-1:0]    cfg_data,
	input  logic [bffm_pkg::COORD_W-1:0]  pixel_x,
	input  logic [bffm_pkg::COORD_W-1:0]  pixel_y,
	input  logic [bffm_pkg::VALUE_W-1:0]  pixel_value,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          found,
	output logic [bffm_pkg::CNT_W-1:0]    pixel_count,
	output logic [bffm_pkg::SUM_W-1:0]    sum_x,
	output logic [bffm_pkg::SUM_W-1:0]    sum_y,
	output logic [bffm_pkg::SQ_W-1:0]     sum_xx,
	output logic [bffm_pkg::SQ_W-1:0]     sum_yy,
	output logic [bffm_pkg::XY_W-1:0]     sum_xy,
	output logic [bffm_pkg::COORD_W-1:0]  seed_x,
	output logic [bffm_pkg::COORD_W-1:0]  seed_y
);
	import bffm_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DEPTH = 2 ** AW;

	// pixel store: bit 1 foreground, bit 0 visited
	logic [1:0] pix_mem [DEPTH];
	logic [AW-1:0] stk_mem [DEPTH];

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [AW-1:0] clr_q;
	logic [XW-1:0] scan_x_q;
	logic [YW-1:0] scan_y_q;
	logic scan_end_q;
	logic [AW:0] depth_q;
	logic [2:0] k_q;
	logic [XW-1:0] cur_x_q;
	logic [YW-1:0] cur_y_q;
	logic [AW-1:0] nb_addr_q;
	logic inb_q;
	logic [1:0] rd_q;
	logic [AW-1:0] stk_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sx_q;
	logic [SUM_W-1:0] sy_q;
	logic [SQ_W-1:0] sxx_q;
	logic [SQ_W-1:0] syy_q;
	logic [XY_W-1:0] sxy_q;
	logic [XW-1:0] seed_x_q;
	logic [YW-1:0] seed_y_q;

	logic out_valid_q;
	logic found_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic [SUM_W-1:0] sx_out_q;
	logic [SUM_W-1:0] sy_out_q;
	logic [SQ_W-1:0] sxx_out_q;
	logic [SQ_W-1:0] syy_out_q;
	logic [XY_W-1:0] sxy_out_q;
	logic [COORD_W-1:0] seed_x_out_q;
	logic [COORD_W-1:0] seed_y_out_q;

	logic [CW-1:0] w_eff;
	logic [CW-1:0] h_eff;
	logic [CW-1:0] nx_w;
	logic [CW-1:0] ny_w;
	logic nb_inb;
	logic scan_inb;
	logic [AW-1:0] scan_addr;
	logic [AW-1:0] nb_addr;
	logic [CW-1:0] px_ext;
	logic [CW-1:0] py_ext;
	logic [AW-1:0] rd_addr;
	logic rd_en;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [1:0] wr_data;
	logic scan_hit;
	logic nb_push;
	logic [AW:0] depth_dec;
	logic [XW-1:0] tk_x;
	logic [YW-1:0] tk_y;
	logic [2*XW-1:0] pxx;
	logic [2*YW-1:0] pyy;
	logic [AW-1:0] pxy;
	logic [CW-1:0] seed_x_ext;
	logic [CW-1:0] seed_y_ext;

	always_comb begin
		w_eff = (CW'(width_q) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_q);
		h_eff = (CW'(height_q) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_q);
		nx_w = CW'(cur_x_q) + {{(CW-2){NB_DX[k_q][1]}}, NB_DX[k_q]};
		ny_w = CW'(cur_y_q) + {{(CW-2){NB_DY[k_q][1]}}, NB_DY[k_q]};
		nb_inb = (nx_w < w_eff) && (ny_w < h_eff);
		nb_addr = {ny_w[YW-1:0], nx_w[XW-1:0]};
		scan_inb = (CW'(scan_x_q) < w_eff) && (CW'(scan_y_q) < h_eff);
		scan_addr = {scan_y_q, scan_x_q};
		px_ext = CW'(pixel_x);
		py_ext = CW'(pixel_y);
		scan_hit = inb_q && rd_q[1] && !rd_q[0];
		nb_push = cmd.nb_chk && inb_q && rd_q[1] && !rd_q[0];
		depth_dec = depth_q - 1'b1;
		tk_x = stk_q[XW-1:0];
		tk_y = stk_q[AW-1:XW];
		pxx = tk_x * tk_x;
		pyy = tk_y * tk_y;
		pxy = tk_x * tk_y;
		seed_x_ext = CW'(seed_x_q);
		seed_y_ext = CW'(seed_y_q);
	end

	always_comb begin
		rd_en = cmd.scan_rd || cmd.nb_rd;
		rd_addr = cmd.scan_rd ? scan_addr : nb_addr;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = 2'b00;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
		end else if (cmd.pix_wr) begin
			wr_en = (px_ext < CW'(MAX_WIDTH)) && (py_ext < CW'(MAX_HEIGHT));
			wr_addr = {py_ext[YW-1:0], px_ext[XW-1:0]};
			wr_data = {pixel_value == FG_VALUE, 1'b0};
		end else if (cmd.scan_chk) begin
			wr_en = scan_hit;
			wr_addr = scan_addr;
			wr_data = 2'b11;
		end else if (cmd.nb_chk) begin
			wr_en = nb_push;
			wr_addr = nb_addr_q;
			wr_data = 2'b11;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) pix_mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= pix_mem[rd_addr];
		if (cmd.scan_chk && scan_hit) stk_mem[0] <= scan_addr;
		if (nb_push) stk_mem[depth_q[AW-1:0]] <= nb_addr_q;
		if (cmd.pop_rd) stk_q <= stk_mem[depth_dec[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) inb_q <= scan_inb;
		if (cmd.nb_rd) begin
			inb_q <= nb_inb;
			nb_addr_q <= nb_addr;
		end
		if (cmd.scan_chk && scan_hit) begin
			seed_x_q <= scan_x_q;
			seed_y_q <= scan_y_q;
			cnt_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
		end
		if (cmd.take) begin
			cur_x_q <= tk_x;
			cur_y_q <= tk_y;
			cnt_q <= cnt_q + 1'b1;
			sx_q <= sx_q + SUM_W'(tk_x);
			sy_q <= sy_q + SUM_W'(tk_y);
			sxx_q <= sxx_q + SQ_W'(pxx);
			syy_q <= syy_q + SQ_W'(pyy);
			sxy_q <= sxy_q + XY_W'(pxy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(64);
			height_q <= DIM_W'(64);
			clr_q <= '0;
			scan_x_q <= '0;
			scan_y_q <= '0;
			scan_end_q <= 1'b0;
			depth_q <= '0;
			k_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_WIDTH: width_q <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default: width_q <= width_q;
				endcase
			end
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.pix_wr) begin
				scan_x_q <= '0;
				scan_y_q <= '0;
				scan_end_q <= 1'b0;
			end else if (cmd.scan_chk) begin
				if (32'(scan_x_q) == MAX_WIDTH - 1) begin
					scan_x_q <= '0;
					if (32'(scan_y_q) == MAX_HEIGHT - 1) begin
						scan_end_q <= 1'b1;
					end else begin
						scan_y_q <= scan_y_q + 1'b1;
					end
				end else begin
					scan_x_q <= scan_x_q + 1'b1;
				end
			end
			if (cmd.scan_chk && scan_hit) begin
				depth_q <= (AW+1)'(1);
			end else if (cmd.pop_rd) begin
				depth_q <= depth_dec;
			end else if (nb_push) begin
				depth_q <= depth_q + 1'b1;
			end
			if (cmd.take) begin
				k_q <= '0;
			end else if (cmd.nb_chk) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			found_q <= cmd.res_found;
			cnt_out_q <= cmd.res_found ? cnt_q : '0;
			sx_out_q <= cmd.res_found ? sx_q : '0;
			sy_out_q <= cmd.res_found ? sy_q : '0;
			sxx_out_q <= cmd.res_found ? sxx_q : '0;
			syy_out_q <= cmd.res_found ? syy_q : '0;
			sxy_out_q <= cmd.res_found ? sxy_q : '0;
			seed_x_out_q <= cmd.res_found ? seed_x_ext[COORD_W-1:0] : '0;
			seed_y_out_q <= cmd.res_found ? seed_y_ext[COORD_W-1:0] : '0;
		end
	end

	always_comb begin
		status.clr_done = &clr_q;
		status.scan_end = scan_end_q;
		status.scan_hit = scan_hit;
		status.stack_empty = depth_q == '0;
		status.nb_last = k_q == 3'd7;
		status.out_busy = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign pixel_count = cnt_out_q;
	assign sum_x = sx_out_q;
	assign sum_y = sy_out_q;
	assign sum_xx = sxx_out_q;
	assign sum_yy = syy_out_q;
	assign sum_xy = sxy_out_q;
	assign seed_x = seed_x_out_q;
	assign seed_y = seed_y_out_q;

endmodule

// ===== rtl/blob_flood_fill_moments.sv =====
// Blob finder: pixel loading, raster search and 8-connected flood fill with raw moments.
// Input channel in_valid/in_ready: command 0 writes one pixel (foreground when the byte
// is 1, visited mark cleared, scan restarted), command 1 finds the next blob.
// Output channel out_valid/out_ready carries one result per find: found, pixel count,
// sums of x, y, x*x, y*y, x*y and the seed position; found=0 with zero fields when
// no blob remains. Config channel cfg_valid/cfg_ready writes image_width (index 0)
// or image_height (index 1); cfg_ready is always high.
// A pixel write keeps the block in its idle state, so in_ready stays high for the next item.
// A find scans raster positions, each with a read then a check of the pixel store,
// plus per blob pixel a stack pop and take, then a read and check of each of the 8
// neighbors, plus the empty stack check of a hit or the scan end check of a miss,
// plus a load of the result register.
// After reset the pixel store is cleared, one entry per cycle, over all
// 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries (4096 at the defaults) with
// in_ready low. Registers reset to 64.
// The result sits in an output register: pixel writes keep flowing while it waits;
// a find holds at its end until the register is free.
// Depends on bffm_pkg, bffm_ctrl and bffm_datapath.
`timescale 1ns / 1ps

module blob_flood_fill_moments #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [bffm_pkg::COORD_W-1:0]  pixel_x,
	input  logic [bffm_pkg::COORD_W-1:0]  pixel_y,
	input  logic [bffm_pkg::VALUE_W-1:0]  pixel_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [bffm_pkg::CNT_W-1:0]    pixel_count,
	output logic [bffm_pkg::SUM_W-1:0]    sum_x,
	output logic [bffm_pkg::SUM_W-1:0]    sum_y,
	output logic [bffm_pkg::SQ_W-1:0]     sum_xx,
	output logic [bffm_pkg::SQ_W-1:0]     sum_yy,
	output logic [bffm_pkg::XY_W-1:0]     sum_xy,
	output logic [bffm_pkg::COORD_W-1:0]  seed_x,
	output logic [bffm_pkg::COORD_W-1:0]  seed_y,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [bffm_pkg::DIM_W-1:0]    cfg_data
);
	import bffm_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	bffm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bffm_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_value (pixel_value),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.found       (found),
		.pixel_count (pixel_count),
		.sum_x       (sum_x),
		.sum_y       (sum_y),
		.sum_xx      (sum_xx),
		.sum_yy      (sum_yy),
		.sum_xy      (sum_xy),
		.seed_x      (seed_x),
		.seed_y      (seed_y)
	);

endmodule

// ===== rtl/bffm_checker.sv =====
// port level checks for blob_flood_fill_moments, attached by bind
// depends on bffm_pkg for field widths
`timescale 1ns / 1ps

module bffm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          command,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          found,
	input logic [bffm_pkg::CNT_W-1:0]    pixel_count,
	input logic [bffm_pkg::SUM_W-1:0]    sum_x,
	input logic [bffm_pkg::SUM_W-1:0]    sum_y,
	input logic [bffm_pkg::SQ_W-1:0]     sum_xx,
	input logic [bffm_pkg::SQ_W-1:0]     sum_yy,
	input logic [bffm_pkg::XY_W-1:0]     sum_xy,
	input logic [bffm_pkg::COORD_W-1:0]  seed_x,
	input logic [bffm_pkg::COORD_W-1:0]  seed_y
);
	import bffm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(pixel_count))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> pixel_count == '0 && sum_x == '0 && sum_y == '0 &&
			sum_xx == '0 && sum_yy == '0 && sum_xy == '0 && seed_x == '0 && seed_y == '0)
		else $error("empty result carries nonzero fields");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found && sum_x != '0 |-> pixel_count != '0)
		else $error("blob with coordinates but no pixels");

	a_find_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_FIND |=> !in_ready)
		else $error("input taken during a find");

endmodule

bind blob_flood_fill_moments bffm_checker u_bffm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.command     (command),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.found       (found),
	.pixel_count (pixel_count),
	.sum_x       (sum_x),
	.sum_y       (sum_y),
	.sum_xx      (sum_xx),
	.sum_yy      (sum_yy),
	.sum_xy      (sum_xy),
	.seed_x      (seed_x),
	.seed_y      (seed_y)
);

// ===== dv/tb_blob_flood_fill_moments.sv =====
// testbench for blob_flood_fill_moments: loads binary images, finds blobs and checks
// count, moments and seed of every result against a flood fill predictor in a scoreboard
// depends on bffm_pkg and the blob_flood_fill_moments rtl
`timescale 1ns / 1ps

module tb_blob_flood_fill_moments;
	import bffm_pkg::*;

	localparam int MAXW = 64;
	localparam int MAXH = 64;
	localparam int NPIX = MAXW * MAXH;
	localparam int SUBW = 12;

	typedef struct {
		logic              found;
		logic [CNT_W-1:0]   pixel_count;
		logic [SUM_W-1:0]   sum_x;
		logic [SUM_W-1:0]   sum_y;
		logic [SQ_W-1:0]    sum_xx;
		logic [SQ_W-1:0]    sum_yy;
		logic [XY_W-1:0]    sum_xy;
		logic [COORD_W-1:0] seed_x;
		logic [COORD_W-1:0] seed_y;
	} blob_res_t;

	class blob_scoreboard;
		bit        fg_map [NPIX];
		bit        seen_map [NPIX];
		int        scan_pos;
		int        img_w;
		int        img_h;
		blob_res_t blob_q[$];
		int        errors;
		int        n_hits;
		int        n_misses;
		bit        last_found;

		function new();
			img_w = 64;
			img_h = 64;
			scan_pos = 0;
			errors = 0;
			n_hits = 0;
			n_misses = 0;
			last_found = 0;
			foreach (seen_map[i]) seen_map[i] = 0;
			foreach (fg_map[i]) fg_map[i] = 0;
		endfunction

		function void set_reg(logic idx, logic [DIM_W-1:0] data);
			if (idx == REG_WIDTH) img_w = data;
			else img_h = data;
		endfunction

		function void note_item(logic cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [VALUE_W-1:0] v);
			int        wd, ht, seed, p, px, py, nx, ny, a;
			longint    cnt, sx, sy, sxx, syy, sxy;
			int        stk [NPIX];
			int        sp;
			bit        hit;
			blob_res_t r;
			if (cmd == CMD_WRITE) begin
				a = y * MAXW + x;
				fg_map[a] = (v == FG_VALUE);
				seen_map[a] = 0;
				scan_pos = 0;
				return;
			end
			wd = img_w > MAXW ? MAXW : img_w;
			ht = img_h > MAXH ? MAXH : img_h;
			hit = 0;
			seed = 0;
			sp = 0;
			while (scan_pos < NPIX) begin
				px = scan_pos % MAXW;
				py = scan_pos / MAXW;
				if (px < wd && py < ht && fg_map[scan_pos] && !seen_map[scan_pos]) begin
					seed = scan_pos;
					hit = 1;
					scan_pos++;
					break;
				end
				scan_pos++;
			end
			r = '{default: 0};
			cnt = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
			if (hit) begin
				stk[sp] = seed;
				sp++;
				seen_map[seed] = 1;
				while (sp > 0) begin
					sp--;
					p = stk[sp];
					px = p % MAXW;
					py = p / MAXW;
					cnt++;
					sx += px;
					sy += py;
					sxx += px * px;
					syy += py * py;
					sxy += px * py;
					for (int k = 0; k < 8; k++) begin
						nx = px + int'(NB_DX[k]);
						ny = py + int'(NB_DY[k]);
						if (nx < 0 || ny < 0 || nx >= wd || ny >= ht) continue;
						a = ny * MAXW + nx;
						if (fg_map[a] && !seen_map[a]) begin
							seen_map[a] = 1;
							stk[sp] = a;
							sp++;
						end
					end
				end
				r.found = 1;
				r.pixel_count = cnt[CNT_W-1:0];
				r.sum_x = sx[SUM_W-1:0];
				r.sum_y = sy[SUM_W-1:0];
				r.sum_xx = sxx[SQ_W-1:0];
				r.sum_yy = syy[SQ_W-1:0];
				r.sum_xy = sxy[XY_W-1:0];
				r.seed_x = COORD_W'(seed % MAXW);
				r.seed_y = COORD_W'(seed / MAXW);
			end
			blob_q.insert(blob_q.size(), r);
		endfunction

		function void cmp(string name, logic [31:0] e, logic [31:0] act);
			if (e !== act) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, act);
			end
		endfunction

		function void check_result(blob_res_t act);
			blob_res_t e;
			if (blob_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual found=%0d count=%0d",
					$time, act.found, act.pixel_count);
				return;
			end
			e = blob_q.pop_front();
			last_found = e.found;
			if (e.found) n_hits++;
			else n_misses++;
			cmp("found", e.found, act.found);
			cmp("pixel_count", e.pixel_count, act.pixel_count);
			cmp("sum_x", e.sum_x, act.sum_x);
			cmp("sum_y", e.sum_y, act.sum_y);
			cmp("sum_xx", e.sum_xx, act.sum_xx);
			cmp("sum_yy", e.sum_yy, act.sum_yy);
			cmp("sum_xy", e.sum_xy, act.sum_xy);
			cmp("seed_x", e.seed_x, act.seed_x);
			cmp("seed_y", e.seed_y, act.seed_y);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               command;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [VALUE_W-1:0] pixel_value;
	logic               out_valid;
	logic               out_ready;
	logic               found;
	logic [CNT_W-1:0]   pixel_count;
	logic [SUM_W-1:0]   sum_x;
	logic [SUM_W-1:0]   sum_y;
	logic [SQ_W-1:0]    sum_xx;
	logic [SQ_W-1:0]    sum_yy;
	logic [XY_W-1:0]    sum_xy;
	logic [COORD_W-1:0] seed_x;
	logic [COORD_W-1:0] seed_y;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [DIM_W-1:0]   cfg_data;

	blob_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int n_items;
	int cur_w;
	int cur_h;

	blob_flood_fill_moments dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#500ms;
		$display("FAILED: results differ");
		$finish;
	end

	// receiver side
	initial begin
		blob_res_t act;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				act.found = found;
				act.pixel_count = pixel_count;
				act.sum_x = sum_x;
				act.sum_y = sum_y;
				act.sum_xx = sum_xx;
				act.sum_yy = sum_yy;
				act.sum_xy = sum_xy;
				act.seed_x = seed_x;
				act.seed_y = seed_y;
				sb.check_result(act);
			end
			@(negedge clk);
			out_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [VALUE_W-1:0] bg_value();
		logic [VALUE_W-1:0] v;
		v = VALUE_W'($urandom);
		if (v == FG_VALUE) v = '0;
		return v;
	endfunction

	task automatic send_item(logic cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
		logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 0;
		end
		@(negedge clk);
		in_valid = 1;
		command = cmd;
		pixel_x = x;
		pixel_y = y;
		pixel_value = v;
		do @(posedge clk); while (!in_ready);
		sb.note_item(cmd, x, y, v);
		n_items++;
	endtask

	task automatic write_pixel(int x, int y, logic [VALUE_W-1:0] v);
		send_item(CMD_WRITE, COORD_W'(x), COORD_W'(y), v);
	endtask

	task automatic find_blob();
		send_item(CMD_FIND, COORD_W'($urandom), COORD_W'($urandom), VALUE_W'($urandom));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (sb.blob_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [DIM_W-1:0] data);
		drain();
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic fill_square();
		for (int y = 0; y < SUBW; y++)
			for (int x = 0; x < SUBW; x++)
				write_pixel(x, y, FG_VALUE);
	endtask

	// finds until the image has no blob left
	task automatic find_all();
		do begin
			find_blob();
			drain();
		end while (sb.last_found);
	endtask

	initial begin
		int dim;
		int pick;
		sb = new();
		arst_n = 0;
		in_valid = 0;
		command = CMD_WRITE;
		pixel_x = 0;
		pixel_y = 0;
		pixel_value = 0;
		cfg_valid = 0;
		cfg_index = REG_WIDTH;
		cfg_data = 0;
		send_idle_pct = 25;
		recv_idle_pct = 60;
		n_items = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// foreground square as one blob, then a miss
		write_reg(REG_WIDTH, DIM_W'(SUBW));
		write_reg(REG_HEIGHT, DIM_W'(SUBW));
		fill_square();
		find_blob();
		find_blob();
		// row 0 and column 0 across the whole storage with far singletons
		for (int i = SUBW; i < MAXW; i++) write_pixel(i, 0, bg_value());
		for (int i = SUBW; i < MAXH; i++) write_pixel(0, i, bg_value());
		write_pixel(MAXW - 1, 0, FG_VALUE);
		write_pixel(0, MAXH - 1, FG_VALUE);
		write_pixel(MAXW - 3, 0, FG_VALUE);
		write_pixel(0, MAXH - 3, FG_VALUE);
		write_pixel(MAXW - 5, 0, 8'hff);
		write_pixel(0, MAXH - 5, 8'h03);
		// saturated width on one row, saturated height on one column
		write_reg(REG_WIDTH, 7'd127);
		write_reg(REG_HEIGHT, 7'd1);
		repeat (3) find_blob();
		write_reg(REG_WIDTH, 7'd1);
		write_reg(REG_HEIGHT, 7'd127);
		repeat (3) find_blob();
		// empty region
		write_reg(REG_WIDTH, 7'd0);
		write_pixel(5, 5, FG_VALUE);
		find_blob();

		while (n_items < 700) begin
			if (n_items < 233) begin
				send_idle_pct = 25;
				recv_idle_pct = 60;
			end else if (n_items < 466) begin
				send_idle_pct = 60;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pick = $urandom_range(99);
			if (pick < 80) begin
				dim = $urandom_range(SUBW, 1);
				write_reg(REG_WIDTH, DIM_W'(dim));
				cur_w = dim;
				dim = $urandom_range(SUBW, 1);
				write_reg(REG_HEIGHT, DIM_W'(dim));
				cur_h = dim;
			end else if (pick < 90) begin
				dim = $urandom_range(127, MAXW);
				write_reg(REG_WIDTH, DIM_W'(dim));
				write_reg(REG_HEIGHT, 7'd1);
				cur_w = MAXW;
				cur_h = 1;
			end else begin
				dim = $urandom_range(127, MAXH);
				write_reg(REG_WIDTH, 7'd1);
				write_reg(REG_HEIGHT, DIM_W'(dim));
				cur_w = 1;
				cur_h = MAXH;
			end
			repeat ($urandom_range(40, 10)) begin
				int x, y;
				logic [VALUE_W-1:0] v;
				if ($urandom_range(9) < 8) begin
					x = $urandom_range(cur_w - 1);
					y = $urandom_range(cur_h - 1);
				end else begin
					x = $urandom_range(63);
					y = $urandom_range(63);
				end
				pick = $urandom_range(99);
				v = pick < 50 ? FG_VALUE : pick < 80 ? 8'd0 : 8'($urandom);
				write_pixel(x, y, v);
				if ($urandom_range(99) < 12) find_blob();
			end
			find_all();
		end

		drain();
		repeat (50) @(negedge clk);
		$display("covered %0d input items over square, row and column regions with stalls;",
			n_items);
		$display("%0d blobs found, %0d empty finds", sb.n_hits, sb.n_misses);
		if (sb.errors == 0 && sb.blob_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
